// ===== sv/idru_pkg.sv =====
// Shared constants, types and the divide step for the integer divide/remainder unit.
`default_nettype none
package idru_pkg;

  localparam int DataWidth  = 32;
  // Queue depth must be a power of two so the pointers wrap on their own.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [DataWidth-1:0] word_t;

  typedef enum logic [1:0] {
    CmdDivS = 2'd0,
    CmdDivU = 2'd1,
    CmdRemS = 2'd2,
    CmdRemU = 2'd3
  } cmd_t;

  // Classified operation as it leaves the front end.
  typedef struct packed {
    word_t mag_a;
    word_t mag_b;
    logic  neg_q;
    logic  neg_r;
    logic  want_rem;
    logic  div_zero;
  } div_op_t;

  // State carried through one restoring-division stage.
  typedef struct packed {
    word_t rem;
    word_t aq;
    word_t mag_b;
    logic  neg_q;
    logic  neg_r;
    logic  want_rem;
    logic  div_zero;
  } step_t;

  // One restoring step: bring down the next dividend bit, trial subtract.
  function automatic step_t div_step(input step_t s);
    logic [DataWidth:0] trial;
    step_t              n;
    trial = {s.rem, s.aq[DataWidth-1]} - {1'b0, s.mag_b};
    n = s;
    if (!trial[DataWidth]) begin
      n.rem = trial[DataWidth-1:0];
      n.aq  = {s.aq[DataWidth-2:0], 1'b1};
    end else begin
      n.rem = {s.rem[DataWidth-2:0], s.aq[DataWidth-1]};
      n.aq  = {s.aq[DataWidth-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== sv/idru_if.sv =====
// Request and response channel interfaces of the divide/remainder unit.
`default_nettype none
interface idru_req_if;
  import idru_pkg::*;
  logic       valid;
  logic       ready;
  word_t      dividend;
  word_t      divisor;
  logic [1:0] command;

  modport source (output valid, output dividend, output divisor, output command, input ready);
  modport sink (input valid, input dividend, input divisor, input command, output ready);
endinterface

interface idru_rsp_if;
  import idru_pkg::*;
  logic  valid;
  logic  ready;
  word_t result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface
`default_nettype wire

// ===== sv/integer_divide_remainder_unit.sv =====
// Top level of the RISC-V style 32-bit divide/remainder unit.
//
//   channel    direction  fields                         handshake
//   request    in         dividend, divisor, command     valid/ready
//   response   out        result                         valid/ready
//
// Throughput is one item per cycle unless response stalls; the divider is a
// pipeline of DataWidth restoring stages, each resolving one quotient bit with
// one subtract. Without stalls a request goes through the front register, the
// queue, DataWidth divide stages, then the sign fix-up register driving response.
// Reset is synchronous on rst and clears only the valid and pointer state.
// A stalled response freezes the divider pipeline as a whole; the queue keeps
// absorbing items from the front end until it fills, then request.ready drops.
`default_nettype none
module integer_divide_remainder_unit (
  input  wire         clk,
  input  wire         rst,
  idru_req_if.sink    request,
  idru_rsp_if.source  response
);
  import idru_pkg::*;

  // Front end to queue.
  logic    push;
  div_op_t push_op;
  logic    queue_full;

  // Queue to divider pipeline.
  div_op_t head;
  logic    not_empty;
  logic    pop;

  // Accept and classify: magnitudes, result sign, divide-by-zero flag.
  idru_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .push       (push),
    .push_op    (push_op),
    .queue_full (queue_full)
  );

  // Decouple the front end from pipeline stalls.
  idru_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // Divide, fix up signs and special cases, present the result.
  idru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .response  (response)
  );

endmodule
`default_nettype wire

// ===== sv/idru_front.sv =====
// Front end: accept a request, classify signs and special cases, hold it for the queue.
`default_nettype none
module idru_front (
  input  wire               clk,
  input  wire               rst,
  idru_req_if.sink          request,
  output logic              push,
  output idru_pkg::div_op_t push_op,
  input  wire               queue_full
);
  import idru_pkg::*;

  logic    held;
  div_op_t op;
  div_op_t op_next;
  logic    is_signed;
  logic    want_rem;
  logic    neg_a;
  logic    neg_b;
  logic    div_zero;

  always_comb begin
    case (cmd_t'(request.command))
      CmdDivS: begin is_signed = 1'b1; want_rem = 1'b0; end
      CmdDivU: begin is_signed = 1'b0; want_rem = 1'b0; end
      CmdRemS: begin is_signed = 1'b1; want_rem = 1'b1; end
      CmdRemU: begin is_signed = 1'b0; want_rem = 1'b1; end
      default: begin is_signed = 1'b0; want_rem = 1'b0; end
    endcase
  end

  always_comb begin
    div_zero = (request.divisor == '0);
    // Divide by zero keeps the raw dividend so the remainder comes out unchanged.
    neg_a = is_signed & request.dividend[DataWidth-1] & ~div_zero;
    neg_b = is_signed & request.divisor[DataWidth-1];
    op_next.mag_a    = neg_a ? (~request.dividend + word_t'(1)) : request.dividend;
    op_next.mag_b    = neg_b ? (~request.divisor + word_t'(1)) : request.divisor;
    op_next.neg_q    = neg_a ^ neg_b;
    op_next.neg_r    = neg_a;
    op_next.want_rem = want_rem;
    op_next.div_zero = div_zero;
  end

  assign push          = held;
  assign push_op       = op;
  assign request.ready = ~held | ~queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (request.valid && request.ready) begin
      held <= 1'b1;
    end else if (!queue_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      op <= op_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/idru_queue.sv =====
// Short FIFO between the front end and the divider pipeline.
`default_nettype none
module idru_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  idru_pkg::div_op_t push_op,
  output logic              full,
  input  wire               pop,
  output idru_pkg::div_op_t head,
  output logic              not_empty
);
  import idru_pkg::*;

  div_op_t              entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule
`default_nettype wire

// ===== sv/idru_back.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage, then sign fix-up.
`default_nettype none
module idru_back (
  input  wire               clk,
  input  wire               rst,
  input  idru_pkg::div_op_t head,
  input  wire               not_empty,
  output logic              pop,
  idru_rsp_if.source        response
);
  import idru_pkg::*;

  step_t stage [DataWidth];
  logic  stage_valid [DataWidth];
  step_t first;
  step_t last;
  logic  advance;
  logic  out_valid;
  word_t result;
  word_t result_next;
  word_t pick;
  logic  pick_neg;

  // The whole pipeline moves together whenever the output slot frees up.
  assign advance = ~out_valid | response.ready;
  assign pop     = advance & not_empty;

  always_comb begin
    first.rem      = '0;
    first.aq       = head.mag_a;
    first.mag_b    = head.mag_b;
    first.neg_q    = head.neg_q;
    first.neg_r    = head.neg_r;
    first.want_rem = head.want_rem;
    first.div_zero = head.div_zero;
  end

  assign last = stage[DataWidth-1];

  always_comb begin
    pick        = last.want_rem ? last.rem : last.aq;
    pick_neg    = last.want_rem ? last.neg_r : last.neg_q;
    result_next = pick_neg ? (~pick + word_t'(1)) : pick;
    if (last.div_zero && !last.want_rem) begin
      result_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DataWidth; i++) begin
        stage_valid[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (advance) begin
      stage_valid[0] <= not_empty;
      for (int i = 1; i < DataWidth; i++) begin
        stage_valid[i] <= stage_valid[i-1];
      end
      out_valid <= stage_valid[DataWidth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage[0] <= div_step(first);
      for (int i = 1; i < DataWidth; i++) begin
        stage[i] <= div_step(stage[i-1]);
      end
      result <= result_next;
    end
  end

  assign response.valid  = out_valid;
  assign response.result = result;

endmodule
`default_nettype wire
